// File: hdl/isometric_project_and_fit_viewport_unit_macros.svh
// assertion macros for the isometric projection and viewport fit unit
// expects clk and rst_n in the scope where a macro is used
`ifndef ISOMETRIC_PROJECT_AND_FIT_VIEWPORT_UNIT_MACROS_SVH
`define ISOMETRIC_PROJECT_AND_FIT_VIEWPORT_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define IPFV_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IPFV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ipfv_pkg.sv
// shared types, widths and codes of the isometric projection and viewport fit unit
// no dependencies
package ipfv_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 12;
    localparam int PROJ_W     = COORD_W + 2;
    localparam int SPAN_W     = PROJ_W;
    localparam int SCALE_W    = 10;
    localparam int FIT_NUMER  = 1000;
    localparam int STEP_W     = $clog2(SCALE_W);
    localparam int PROD_W     = SPAN_W + SCALE_W;
    localparam int SIZE_W     = 13;
    localparam int SIZE_RESET = 1000;
    localparam int OUT_W      = 16;
    localparam int OUT_MAX    = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN    = -(1 << (OUT_W - 1));
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FIT   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_SPAN = 2'd1,
        ST_BEYOND    = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_LOAD,
        RES_FIT,
        RES_READ,
        RES_ERR
    } res_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     clear_set;
        logic     load_point;
        logic     fit_empty;
        logic     div_start;
        logic     div_sel_y;
        logic     scale_wr_x;
        logic     scale_wr_y;
        logic     fit_set;
        logic     rd_issue;
        logic     rd_mul;
        res_sel_t res_sel;
        status_t  res_status;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd_code;
        logic set_full;
        logic set_empty;
        logic idx_beyond;
        logic fitted;
        logic div_done;
    } dp_stat_t;

endpackage

// File: hdl/isometric_project_and_fit_viewport_unit.sv
// top level of the isometric projection and viewport fit unit
// depends on ipfv_pkg, ipfv_ctrl, ipfv_dp and the assertion macro header
`include "isometric_project_and_fit_viewport_unit_macros.svh"

// A command is transferred at a rising edge with start high and busy low; busy
// then stays high until the unit can take the next command. Each result is
// shown for exactly one cycle with done high and cannot be held off, so the
// receiver must take it in that cycle; a clear gives no result. Clear and load
// finish in the execute state, with the load result (projected point, or
// status 3 when the store is full) shown as busy falls. A read has one
// point-store access with registered read data, one multiply stage and one
// add and saturate stage. A fit runs a shared bit-serial divider once per
// axis, ten quotient bits one a cycle, and writes each quotient to its axis
// scale register; fit and read errors finish like a load.
// screen_width and screen_height may be written through cfg_we, cfg_index and
// cfg_data whenever no command is in flight; they reset to 1000. The point
// store is not cleared after reset and needs no clearing pass: reads are only
// served below the current point count.
module isometric_project_and_fit_viewport_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     cmd,
    input  logic [ipfv_pkg::COORD_W-1:0]   point_x,
    input  logic [ipfv_pkg::COORD_W-1:0]   point_y,
    input  logic [ipfv_pkg::COORD_W-1:0]   point_z,
    input  logic [ipfv_pkg::IDX_W-1:0]     read_index,
    input  logic                           cfg_we,
    input  logic [ipfv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipfv_pkg::SIZE_W-1:0]    cfg_data,
    output logic [ipfv_pkg::OUT_W-1:0]     screen_x,
    output logic [ipfv_pkg::OUT_W-1:0]     screen_y,
    output logic [1:0]                     status,
    output logic                           done
);
    import ipfv_pkg::*;

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;
    logic      err_result;

    // sequencer: decodes the captured command and drives the datapath steps
    ipfv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // datapath: projection, point store, box, divider, screen mapping
    ipfv_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cmd        (cmd),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .read_index (read_index),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .status     (status),
        .done       (done)
    );

    // result transfer that reports an index or readiness error
    assign err_result = done && (status == ST_BEYOND || status == ST_NOT_READY);

    // a transfer always raises busy in the next cycle
    `IPFV_ASSERT_NEXT(a_transfer_sets_busy, start && !busy, busy, "busy low after a transfer")

    // every result closes a command that held busy the cycle before
    `IPFV_ASSERT_IMPLIES(a_done_follows_busy, done, $past(busy), "result without a command")

    // error results carry zero coordinates
    `IPFV_ASSERT_IMPLIES(a_error_zero, err_result, (screen_x | screen_y) == '0, "error not zero")

endmodule

// File: hdl/ipfv_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ipfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ipfv_div.sv
// bit-serial restoring divider, fixed dividend over a span divisor
// depends on ipfv_pkg
module ipfv_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ipfv_pkg::SPAN_W-1:0]  divisor,
    output logic                         done,
    output logic [ipfv_pkg::SCALE_W-1:0] quotient
);
    import ipfv_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [SPAN_W-1:0] rem_reg, rem_next;
    logic [SPAN_W-1:0] dvs_reg, dvs_next;
    logic [SCALE_W-1:0] quo_reg, quo_next;
    logic [SPAN_W:0]   trial;
    logic [SPAN_W:0]   trial_sub;

    // shift in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, quo_reg[SCALE_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvs_next = divisor;
            quo_next = SCALE_W'(FIT_NUMER);
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial_sub[SPAN_W-1:0];
                quo_next = {quo_reg[SCALE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SPAN_W-1:0];
                quo_next = {quo_reg[SCALE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(SCALE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/ipfv_dp.sv
// datapath: projection, point store, bounding box, scales, screen mapping
// depends on ipfv_pkg, ipfv_ram, ipfv_div
module ipfv_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ipfv_pkg::ctrl_cmd_t            ctrl,
    output ipfv_pkg::dp_stat_t             stat,
    input  logic [1:0]                     cmd,
    input  logic [ipfv_pkg::COORD_W-1:0]   point_x,
    input  logic [ipfv_pkg::COORD_W-1:0]   point_y,
    input  logic [ipfv_pkg::COORD_W-1:0]   point_z,
    input  logic [ipfv_pkg::IDX_W-1:0]     read_index,
    input  logic                           cfg_we,
    input  logic [ipfv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipfv_pkg::SIZE_W-1:0]    cfg_data,
    output logic [ipfv_pkg::OUT_W-1:0]     screen_x,
    output logic [ipfv_pkg::OUT_W-1:0]     screen_y,
    output logic [1:0]                     status,
    output logic                           done
);
    import ipfv_pkg::*;

    localparam int DW = PROD_W + 1;
    localparam int TW = PROD_W + 2;
    localparam logic signed [TW-1:0] SAT_HI = TW'(OUT_MAX);
    localparam logic signed [TW-1:0] SAT_LO = TW'(OUT_MIN);

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [TW-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[OUT_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // captured item
    cmd_t               cmd_reg;
    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [IDX_W-1:0]   idx_reg;

    // set state
    logic [CNT_W-1:0]          count_reg;
    logic                      fitted_reg;
    logic signed [PROJ_W-1:0]  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [SCALE_W-1:0]        scale_x_reg, scale_y_reg;
    logic [SIZE_W-1:0]         width_reg, height_reg;

    // read pipeline
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg, ss_x_reg, ss_y_reg;

    // result
    logic [OUT_W-1:0] sx_reg, sy_reg, sx_next, sy_next;
    status_t          st_reg, st_next;
    logic             done_reg;

    logic signed [PROJ_W-1:0] px, py;
    logic [PROJ_W-1:0]        abs_min_x, abs_min_y;
    logic [SPAN_W-1:0]        span_x, span_y;
    logic [SPAN_W-1:0]        off_x, off_y;
    logic [2*PROJ_W-1:0]      ram_q;
    logic [SCALE_W-1:0]       div_q;
    logic                     div_done;
    logic signed [DW-1:0]     diff_x, diff_y, half_x, half_y;
    logic signed [TW-1:0]     total_x, total_y;

    // isometric projection of the captured point
    assign px = $signed({{2{x_reg[COORD_W-1]}}, x_reg}) - $signed({{2{y_reg[COORD_W-1]}}, y_reg});
    assign py = $signed({{2{x_reg[COORD_W-1]}}, x_reg}) + $signed({{2{y_reg[COORD_W-1]}}, y_reg})
              - $signed({{2{z_reg[COORD_W-1]}}, z_reg});

    // span = |min| + max; never negative for boxes built from loads
    assign abs_min_x = min_x_reg[PROJ_W-1] ? PROJ_W'(-min_x_reg) : min_x_reg;
    assign abs_min_y = min_y_reg[PROJ_W-1] ? PROJ_W'(-min_y_reg) : min_y_reg;
    assign span_x    = abs_min_x + max_x_reg;
    assign span_y    = abs_min_y + max_y_reg;

    ipfv_ram #(
        .WIDTH (2 * PROJ_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ctrl.load_point),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({px, py}),
        .re    (ctrl.rd_issue),
        .raddr (idx_reg),
        .rdata (ram_q)
    );

    ipfv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .divisor  (ctrl.div_sel_y ? span_y : span_x),
        .done     (div_done),
        .quotient (div_q)
    );

    // stored point shifted by |min|, so it starts at zero when the box minimum is not positive
    assign off_x = ram_q[2*PROJ_W-1:PROJ_W] + abs_min_x;
    assign off_y = ram_q[PROJ_W-1:0] + abs_min_y;

    // centring offset, halved toward zero
    assign diff_x  = $signed({{(DW-SIZE_W){1'b0}}, width_reg}) - $signed({1'b0, ss_x_reg});
    assign diff_y  = $signed({{(DW-SIZE_W){1'b0}}, height_reg}) - $signed({1'b0, ss_y_reg});
    assign half_x  = (diff_x + $signed({{(DW-1){1'b0}}, diff_x[DW-1]})) >>> 1;
    assign half_y  = (diff_y + $signed({{(DW-1){1'b0}}, diff_y[DW-1]})) >>> 1;
    assign total_x = $signed({2'b00, prod_x_reg}) + $signed({half_x[DW-1], half_x});
    assign total_y = $signed({2'b00, prod_y_reg}) + $signed({half_y[DW-1], half_y});

    always_comb
    begin
        sx_next = '0;
        sy_next = '0;
        st_next = ST_OK;
        case (ctrl.res_sel)
            RES_LOAD:
            begin
                sx_next = {{(OUT_W-PROJ_W){px[PROJ_W-1]}}, px};
                sy_next = {{(OUT_W-PROJ_W){py[PROJ_W-1]}}, py};
            end
            RES_FIT:
            begin
                sx_next = {{(OUT_W-SCALE_W){1'b0}}, scale_x_reg};
                sy_next = {{(OUT_W-SCALE_W){1'b0}}, scale_y_reg};
                st_next = (span_x == '0 || span_y == '0) ? ST_ZERO_SPAN : ST_OK;
            end
            RES_READ:
            begin
                sx_next = sat_out(total_x);
                sy_next = sat_out(total_y);
            end
            RES_ERR:
            begin
                st_next = ctrl.res_status;
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            fitted_reg  <= 1'b0;
            min_x_reg   <= '0;
            max_x_reg   <= '0;
            min_y_reg   <= '0;
            max_y_reg   <= '0;
            scale_x_reg <= '0;
            scale_y_reg <= '0;
            width_reg   <= SIZE_W'(SIZE_RESET);
            height_reg  <= SIZE_W'(SIZE_RESET);
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.res_sel != RES_NONE);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default:           width_reg  <= width_reg;
                endcase
            end
            if (ctrl.clear_set)
            begin
                count_reg  <= '0;
                fitted_reg <= 1'b0;
            end
            if (ctrl.load_point)
            begin
                count_reg  <= count_reg + 1'b1;
                fitted_reg <= 1'b0;
                if (count_reg == '0)
                begin
                    min_x_reg <= px;
                    max_x_reg <= px;
                    min_y_reg <= py;
                    max_y_reg <= py;
                end
                else
                begin
                    if (px > max_x_reg) max_x_reg <= px;
                    if (px < min_x_reg) min_x_reg <= px;
                    if (py > max_y_reg) max_y_reg <= py;
                    if (py < min_y_reg) min_y_reg <= py;
                end
            end
            if (ctrl.fit_empty)
            begin
                fitted_reg <= 1'b0;
            end
            if (ctrl.scale_wr_x)
            begin
                scale_x_reg <= (span_x == '0) ? '0 : div_q;
            end
            if (ctrl.scale_wr_y)
            begin
                scale_y_reg <= (span_y == '0) ? '0 : div_q;
            end
            if (ctrl.fit_set)
            begin
                fitted_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= cmd_t'(cmd);
            x_reg   <= point_x;
            y_reg   <= point_y;
            z_reg   <= point_z;
            idx_reg <= read_index;
        end
        if (ctrl.rd_mul)
        begin
            prod_x_reg <= off_x * scale_x_reg;
            prod_y_reg <= off_y * scale_y_reg;
            ss_x_reg   <= span_x * scale_x_reg;
            ss_y_reg   <= span_y * scale_y_reg;
        end
        if (ctrl.res_sel != RES_NONE)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            st_reg <= st_next;
        end
    end

    assign stat.cmd_code   = cmd_reg;
    assign stat.set_full   = (count_reg == CNT_W'(MAX_POINTS));
    assign stat.set_empty  = (count_reg == '0);
    assign stat.idx_beyond = (CNT_W'(idx_reg) >= count_reg);
    assign stat.fitted     = fitted_reg;
    assign stat.div_done   = div_done;

    assign screen_x = sx_reg;
    assign screen_y = sy_reg;
    assign status   = st_reg;
    assign done     = done_reg;

endmodule

// File: hdl/ipfv_ctrl.sv
// command sequencer: decodes a captured command and steps the datapath
// depends on ipfv_pkg
module ipfv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ipfv_pkg::dp_stat_t   stat,
    output ipfv_pkg::ctrl_cmd_t  ctrl,
    output logic                 busy
);
    import ipfv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_X,
        S_DIV_Y,
        S_FIT_OUT,
        S_RD_MUL,
        S_RD_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (stat.cmd_code)
                    CMD_CLEAR:
                    begin
                        ctrl.clear_set = 1'b1;
                    end
                    CMD_LOAD:
                    begin
                        if (stat.set_full)
                        begin
                            ctrl.res_sel    = RES_ERR;
                            ctrl.res_status = ST_NOT_READY;
                        end
                        else
                        begin
                            ctrl.load_point = 1'b1;
                            ctrl.res_sel    = RES_LOAD;
                        end
                    end
                    CMD_FIT:
                    begin
                        if (stat.set_empty)
                        begin
                            ctrl.fit_empty  = 1'b1;
                            ctrl.res_sel    = RES_ERR;
                            ctrl.res_status = ST_NOT_READY;
                        end
                        else
                        begin
                            ctrl.div_start = 1'b1;
                            state_next     = S_DIV_X;
                        end
                    end
                    CMD_READ:
                    begin
                        if (stat.idx_beyond)
                        begin
                            ctrl.res_sel    = RES_ERR;
                            ctrl.res_status = ST_BEYOND;
                        end
                        else if (!stat.fitted)
                        begin
                            ctrl.res_sel    = RES_ERR;
                            ctrl.res_status = ST_NOT_READY;
                        end
                        else
                        begin
                            ctrl.rd_issue = 1'b1;
                            state_next    = S_RD_MUL;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV_X:
            begin
                if (stat.div_done)
                begin
                    ctrl.scale_wr_x = 1'b1;
                    ctrl.div_start  = 1'b1;
                    ctrl.div_sel_y  = 1'b1;
                    state_next      = S_DIV_Y;
                end
            end
            S_DIV_Y:
            begin
                ctrl.div_sel_y = 1'b1;
                if (stat.div_done)
                begin
                    ctrl.scale_wr_y = 1'b1;
                    state_next      = S_FIT_OUT;
                end
            end
            S_FIT_OUT:
            begin
                ctrl.fit_set = 1'b1;
                ctrl.res_sel = RES_FIT;
                state_next   = S_IDLE;
            end
            S_RD_MUL:
            begin
                ctrl.rd_mul = 1'b1;
                state_next  = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                ctrl.res_sel = RES_READ;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

// File: test/isometric_project_and_fit_viewport_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench for isometric_project_and_fit_viewport_unit
// predicts projection, bounding box, fit scales and viewport placement on its own
// depends on ipfv_pkg and the unit's rtl
module isometric_project_and_fit_viewport_unit_test;
    import ipfv_pkg::*;

    localparam int ITEM_TARGET   = 1650;
    localparam int CYCLE_LIMIT   = 400000;
    // long enough to cover any command still in flight, a fit included
    localparam int SETTLE_CYCLES = 40;

    // one command as presented on the start side
    typedef struct {
        cmd_t                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          idx;
    } unit_cmd_t;

    // one result as shown with done
    typedef struct {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        status_t          st;
    } screen_res_t;

    // dut connections, all inputs known from time zero
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [1:0]           cmd        = CMD_CLEAR;
    logic [COORD_W-1:0]   point_x    = '0;
    logic [COORD_W-1:0]   point_y    = '0;
    logic [COORD_W-1:0]   point_z    = '0;
    logic [IDX_W-1:0]     read_index = '0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = CFG_SCREEN_WIDTH;
    logic [SIZE_W-1:0]    cfg_data   = '0;
    logic [OUT_W-1:0]     screen_x;
    logic [OUT_W-1:0]     screen_y;
    logic [1:0]           status;
    logic                 done;

    isometric_project_and_fit_viewport_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .read_index (read_index),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .status     (status),
        .done       (done)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: point store, bounding box, scales, viewport size
    // ------------------------------------------------------------------
    logic signed [PROJ_W-1:0] proj_x_mem [MAX_POINTS];
    logic signed [PROJ_W-1:0] proj_y_mem [MAX_POINTS];
    int                       stored_count = 0;
    logic signed [PROJ_W-1:0] lo_x = '0;
    logic signed [PROJ_W-1:0] hi_x = '0;
    logic signed [PROJ_W-1:0] lo_y = '0;
    logic signed [PROJ_W-1:0] hi_y = '0;
    int                       fit_scale_x = 0;
    int                       fit_scale_y = 0;
    bit                       fit_valid = 1'b0;
    int                       view_w = SIZE_RESET;
    int                       view_h = SIZE_RESET;

    screen_res_t expected_screen_q[$];
    unit_cmd_t   pending_cmds[$];
    int          items_queued = 0;
    int          mismatches = 0;

    function automatic logic [OUT_W-1:0] sat_out(input longint v);
        logic [OUT_W-1:0] r;
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
        r = v[OUT_W-1:0];
        return r;
    endfunction

    // span is |min| + max, not max - min; a non-positive span flags the axis
    function automatic int axis_scale(input longint lo, input longint hi, inout bit zero);
        longint span;
        span = ((lo < 0) ? -lo : lo) + hi;
        if (span <= 0) begin
            zero = 1'b1;
            return 0;
        end
        return int'(FIT_NUMER / span);
    endfunction

    // signed division, so the centring offset truncates toward zero
    function automatic longint place_on_screen(input longint p, input longint lo,
                                               input longint hi, input longint sc,
                                               input longint size);
        longint mag_lo;
        mag_lo = (lo < 0) ? -lo : lo;
        return (p + mag_lo) * sc + (size - (mag_lo + hi) * sc) / 2;
    endfunction

    // applies one transferred command to the predictor, queues its result if any
    function automatic void predict_screen_result(input unit_cmd_t c);
        logic signed [PROJ_W-1:0] px;
        logic signed [PROJ_W-1:0] py;
        bit                       zero;
        screen_res_t              r;
        r.sx = '0;
        r.sy = '0;
        r.st = ST_OK;
        zero = 1'b0;
        case (c.op)
            CMD_CLEAR:
            begin
                // box is left as is, the next load sets it again
                stored_count = 0;
                fit_valid = 1'b0;
                return;
            end
            CMD_LOAD:
            begin
                px = PROJ_W'(int'(c.x) - int'(c.y));
                py = PROJ_W'(int'(c.x) + int'(c.y) - int'(c.z));
                if (stored_count >= MAX_POINTS)
                begin
                    // store full: nothing changes, not even the fitted state
                    r.st = ST_NOT_READY;
                end
                else
                begin
                    proj_x_mem[stored_count] = px;
                    proj_y_mem[stored_count] = py;
                    if (stored_count == 0)
                    begin
                        lo_x = px;
                        hi_x = px;
                        lo_y = py;
                        hi_y = py;
                    end
                    else
                    begin
                        if (px > hi_x) hi_x = px;
                        if (px < lo_x) lo_x = px;
                        if (py > hi_y) hi_y = py;
                        if (py < lo_y) lo_y = py;
                    end
                    stored_count++;
                    fit_valid = 1'b0;
                    r.sx = sat_out(px);
                    r.sy = sat_out(py);
                end
            end
            CMD_FIT:
            begin
                if (stored_count == 0)
                begin
                    // empty set keeps the old scales
                    fit_valid = 1'b0;
                    r.st = ST_NOT_READY;
                end
                else
                begin
                    fit_scale_x = axis_scale(lo_x, hi_x, zero);
                    fit_scale_y = axis_scale(lo_y, hi_y, zero);
                    fit_valid = 1'b1;
                    r.sx = sat_out(fit_scale_x);
                    r.sy = sat_out(fit_scale_y);
                    r.st = zero ? ST_ZERO_SPAN : ST_OK;
                end
            end
            default:
            begin
                // index check comes before the fitted check
                if (int'(c.idx) >= stored_count)
                    r.st = ST_BEYOND;
                else if (!fit_valid)
                    r.st = ST_NOT_READY;
                else
                begin
                    r.sx = sat_out(place_on_screen(proj_x_mem[c.idx], lo_x, hi_x,
                                                   fit_scale_x, view_w));
                    r.sy = sat_out(place_on_screen(proj_y_mem[c.idx], lo_y, hi_y,
                                                   fit_scale_y, view_h));
                end
            end
        endcase
        expected_screen_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of commands with random gaps between them
    // ------------------------------------------------------------------
    unit_cmd_t cur_cmd;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || !busy)
        begin
            // start high here means the held command transferred at this edge
            if (start)
                predict_screen_result(cur_cmd);
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                cmd        <= cur_cmd.op;
                point_x    <= cur_cmd.x;
                point_y    <= cur_cmd.y;
                point_z    <= cur_cmd.z;
                read_index <= cur_cmd.idx;
                start      <= 1'b1;
                if (burst_left <= 1)
                begin
                    // new burst, often with no gap at all, now and then a long one
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    if ($urandom_range(0, 15) == 0)
                        gap_left = $urandom_range(10, 30);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done cycle is one result transfer
    // ------------------------------------------------------------------
    screen_res_t oldest_expect;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_screen_q.size() == 0)
            begin
                $error("result with no command waiting: screen_x %0d screen_y %0d status %0d",
                       $signed(screen_x), $signed(screen_y), status);
                mismatches++;
            end
            else
            begin
                oldest_expect = expected_screen_q.pop_front();
                if (screen_x !== oldest_expect.sx)
                begin
                    $error("screen_x: expected %0d, got %0d",
                           $signed(oldest_expect.sx), $signed(screen_x));
                    mismatches++;
                end
                if (screen_y !== oldest_expect.sy)
                begin
                    $error("screen_y: expected %0d, got %0d",
                           $signed(oldest_expect.sy), $signed(screen_y));
                    mismatches++;
                end
                if (status !== oldest_expect.st)
                begin
                    $error("status: expected %0d, got %0d", oldest_expect.st, status);
                    mismatches++;
                end
            end
        end
    end

    // watchdog against a hung unit or lost results
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_cmd(input cmd_t op, input int x, input int y,
                                      input int z, input int idx);
        unit_cmd_t c;
        c.op  = op;
        c.x   = COORD_W'(x);
        c.y   = COORD_W'(y);
        c.z   = COORD_W'(z);
        c.idx = IDX_W'(idx);
        pending_cmds.push_back(c);
        items_queued++;
    endfunction

    // narrow coordinates make repeated points and zero spans likely
    function automatic int rand_coord(input bit narrow);
        if (narrow)
            return int'($urandom_range(0, 6)) - 3;
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic void queue_load(input int x, input int y, input int z);
        queue_cmd(CMD_LOAD, x, y, z, $urandom_range(0, MAX_POINTS - 1));
    endfunction

    function automatic void queue_read(input int idx);
        queue_cmd(CMD_READ, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0), idx);
    endfunction

    // unused payload fields still toggle
    function automatic void queue_plain(input cmd_t op);
        queue_cmd(op, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                  $urandom_range(0, MAX_POINTS - 1));
    endfunction

    // clear, loads, fit, reads, with the odd broken or noisy sequence
    function automatic void queue_random_set();
        int kind;
        int n;
        int m;
        int k;
        int v;
        int bx;
        int by;
        int bz;
        bit narrow;
        kind = $urandom_range(0, 9);
        narrow = (kind < 3);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        if (kind == 4)
            n = 0;
        bx = rand_coord(1'b1);
        by = rand_coord(1'b1);
        bz = rand_coord(1'b1);
        if ($urandom_range(0, 7) != 0)
            queue_plain(CMD_CLEAR);
        for (int i = 0; i < n; i++)
        begin
            if (kind == 3)
            begin
                // same point over and over
                queue_load(bx, by, bz);
            end
            else if (kind == 5)
            begin
                // x equal to y keeps the horizontal projection at zero
                v = rand_coord(1'b0);
                queue_load(v, v, rand_coord(1'b0));
            end
            else
            begin
                queue_load(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow));
            end
        end
        if ($urandom_range(0, 5) == 0)
            queue_read($urandom_range(0, n));
        if ($urandom_range(0, 9) != 0)
            queue_plain(CMD_FIT);
        m = $urandom_range(1, 10);
        for (int i = 0; i < m; i++)
            queue_read(($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_POINTS - 1)
                                                   : $urandom_range(0, n + 1));
        if ($urandom_range(0, 3) == 0)
        begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
                queue_plain(cmd_t'($urandom_range(0, 3)));
        end
    endfunction

    // fills the store to capacity, then pushes past it
    function automatic void queue_full_store();
        queue_plain(CMD_CLEAR);
        for (int i = 0; i < MAX_POINTS + 3; i++)
            queue_load(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
        queue_plain(CMD_FIT);
        queue_read(0);
        queue_read(MAX_POINTS - 1);
        for (int i = 0; i < 16; i++)
            queue_read($urandom_range(0, MAX_POINTS - 1));
        // refused load leaves the fit in place
        queue_load(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
        queue_read($urandom_range(0, MAX_POINTS - 1));
        queue_plain(CMD_CLEAR);
        queue_load(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
        queue_read(0);
    endfunction

    // checked at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_screen_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes both viewport registers, only while the unit is idle
    task automatic program_viewport(input int w, input int h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= SIZE_W'(w);
        @(posedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= SIZE_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        view_w = w;
        view_h = h;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    int phase;
    int w_pick;
    int h_pick;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset viewport of 1000 by 1000
        queue_read(0);                        // index beyond an empty set
        queue_plain(CMD_FIT);                 // fit of an empty set
        queue_load(2047, -2048, -2048);       // largest horizontal projection
        queue_load(-2048, 2047, 2047);        // smallest horizontal projection
        queue_load(-2048, -2048, 2047);       // smallest vertical projection
        queue_load(2047, 2047, -2048);        // largest vertical projection
        queue_load(0, 0, 0);
        queue_read(0);                        // read before fit
        queue_read(MAX_POINTS - 1);           // index beyond count
        queue_plain(CMD_FIT);                 // wide box, scales truncate to zero
        queue_read(0);
        queue_read(4);
        queue_plain(CMD_CLEAR);
        queue_load(0, 0, 0);
        queue_plain(CMD_FIT);                 // zero span on both axes
        queue_read(0);
        queue_plain(CMD_CLEAR);
        queue_load(5, 5, 0);
        queue_load(7, 7, 1);
        queue_plain(CMD_FIT);                 // zero span on one axis only
        queue_read(1);
        queue_plain(CMD_CLEAR);
        queue_load(-3, 0, 0);
        queue_plain(CMD_FIT);                 // single negative point, zero span
        queue_read(0);
        wait_idle();

        // store full
        program_viewport($urandom_range(1, 8191), $urandom_range(1, 8191));
        queue_full_store();
        wait_idle();

        // random sets across viewport settings, extremes among them
        phase = 0;
        while (items_queued < ITEM_TARGET)
        begin
            case (phase % 5)
                0: begin w_pick = 1;    h_pick = 1;    end
                1: begin w_pick = 8191; h_pick = 8191; end
                2: begin w_pick = 1;    h_pick = 8191; end
                3: begin w_pick = 8191; h_pick = 1;    end
                default:
                begin
                    w_pick = $urandom_range(1, 8191);
                    h_pick = $urandom_range(1, 8191);
                end
            endcase
            program_viewport(w_pick, h_pick);
            repeat ($urandom_range(2, 5)) queue_random_set();
            wait_idle();
            phase++;
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
